@@ src/idle_connection_aging_table_macros.svh @@
// Assertion macros shared by the aging table modules.
// Depends on nothing; included by files that carry assertions.
`ifndef IDLE_CONNECTION_AGING_TABLE_MACROS_SVH
`define IDLE_CONNECTION_AGING_TABLE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ICAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icat check failed");
// Next-cycle implication checked outside reset.
`define ICAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icat check failed");
`endif

@@ src/icat_pkg.sv @@
// Package for the idle connection aging table: widths, status codes, command struct.
// Depends on nothing.
package icat_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned HandleW = 31;
  localparam int unsigned AddrW = 64;
  localparam int unsigned SessW = 64;
  localparam int unsigned TimeW = 48;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeW-1:0] MsPerSec = 48'd1000;

  localparam logic [CfgIdxW-1:0] CfgEnable = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b1;

  localparam logic [1:0] ReqMsg = 2'd0;
  localparam logic [1:0] ReqClose = 2'd1;
  localparam logic [1:0] ReqTick = 2'd2;
  localparam logic [1:0] ReqVerdict = 2'd3;

  localparam logic [StatusW-1:0] StInserted = 4'd0;
  localparam logic [StatusW-1:0] StRefreshed = 4'd1;
  localparam logic [StatusW-1:0] StRemoved = 4'd2;
  localparam logic [StatusW-1:0] StNotFound = 4'd3;
  localparam logic [StatusW-1:0] StNoIdle = 4'd4;
  localparam logic [StatusW-1:0] StIdleFound = 4'd5;
  localparam logic [StatusW-1:0] StFull = 4'd6;
  localparam logic [StatusW-1:0] StDisabled = 4'd7;
  localparam logic [StatusW-1:0] StBusy = 4'd8;
  localparam logic [StatusW-1:0] StNoPending = 4'd9;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone, OpLatch, OpScanStep, OpReadIdx, OpWriteNew, OpRefresh, OpUnlinkA,
    OpUnlinkB, OpLinkA, OpLinkB, OpFree, OpKeepTime, OpOldRead, OpEmit
  } op_e;

  typedef struct packed {
    op_e op;
    logic sel_pend;     // OpReadIdx: use pending index instead of found index
    logic [StatusW-1:0] status;
    logic with_entry;
    logic last;
    logic set_pend;
    logic clr_pend;
  } cmd_t;
endpackage

@@ src/icat_datapath.sv @@
// Datapath: entry memories, list links, key scan, result registers.
// Depends on icat_pkg and the assertion macro header.
`include "idle_connection_aging_table_macros.svh"
module icat_datapath import icat_pkg::*; #(
  parameter int unsigned Entries = TableEntries,
  localparam int unsigned IdxW = $clog2(Entries)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic [HandleW-1:0] handle_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [SessW-1:0] sess_i,
  input  logic [TimeW-1:0] now_i,
  input  logic [TimeoutW-1:0] timeout_i,
  output logic scan_done_o,
  output logic found_o,
  output logic has_free_o,
  output logic empty_o,
  output logic idle_o,
  output logic pending_o,
  output logic valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [HandleW-1:0] out_handle_o,
  output logic [AddrW-1:0] out_address_o,
  output logic [SessW-1:0] out_session_o,
  output logic is_last_o
);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  logic [HandleW-1:0] handle_mem [Entries];
  logic [AddrW-1:0] addr_mem [Entries];
  logic [SessW-1:0] sess_mem [Entries];
  logic [TimeW-1:0] time_mem [Entries];
  logic [IdxW-1:0] newer_mem [Entries];
  logic [IdxW-1:0] older_mem [Entries];
  logic [Entries-1:0] valid_q;

  logic [IdxW-1:0] oldest_q, newest_q, pend_idx_q, cur_q, scan_q, free_q, scan_idx_q;
  logic [IdxW:0] count_q;
  logic [TimeW-1:0] now_q;
  logic pend_q, found_q, free_ok_q, scan_done_q, scan_v_q;
  logic [HandleW-1:0] rd_handle_q, key_h_q, scan_h_q;
  logic [AddrW-1:0] rd_addr_q, key_a_q, scan_a_q;
  logic [SessW-1:0] rd_sess_q, sess_q;
  logic [TimeW-1:0] rd_time_q;
  logic [IdxW-1:0] rd_newer_q, rd_older_q;
  logic [TimeW-1:0] tmo_ms_q;
  logic [TimeW:0] limit;
  logic [IdxW-1:0] rd_idx;
  logic hit;

  // scan compare works on the registered copy of the entry key read by the scan step
  assign hit = scan_v_q && scan_h_q == key_h_q && scan_a_q == key_a_q;
  // active time + timeout, one bit wider so it cannot wrap
  assign limit = {1'b0, rd_time_q} + {1'b0, tmo_ms_q};
  // read address: oldest entry, pending entry or current entry
  assign rd_idx = (cmd_i.op == OpOldRead) ? oldest_q : (cmd_i.sel_pend ? pend_idx_q : cur_q);

  // Memory port: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLatch: begin
        key_h_q <= handle_i;
        key_a_q <= addr_i;
        sess_q <= sess_i;
        tmo_ms_q <= TimeW'(timeout_i) * MsPerSec;
      end
      OpScanStep: begin
        scan_h_q <= handle_mem[scan_q];
        scan_a_q <= addr_mem[scan_q];
      end
      OpReadIdx, OpOldRead: begin
        rd_handle_q <= handle_mem[rd_idx];
        rd_addr_q <= addr_mem[rd_idx];
        rd_sess_q <= sess_mem[rd_idx];
        rd_time_q <= time_mem[rd_idx];
        rd_newer_q <= newer_mem[rd_idx];
        rd_older_q <= older_mem[rd_idx];
      end
      OpWriteNew: begin
        handle_mem[free_q] <= key_h_q;
        addr_mem[free_q] <= key_a_q;
        sess_mem[free_q] <= sess_q;
        time_mem[free_q] <= now_q;
        rd_handle_q <= key_h_q;
        rd_addr_q <= key_a_q;
        rd_sess_q <= sess_q;
      end
      OpRefresh: begin
        sess_mem[cur_q] <= sess_q;
        time_mem[cur_q] <= now_q;
        rd_sess_q <= sess_q;
      end
      OpKeepTime: time_mem[cur_q] <= now_q;
      OpUnlinkA: if (!(count_q <= 1) && cur_q != oldest_q && cur_q != newest_q)
        newer_mem[rd_older_q] <= rd_newer_q;
      OpUnlinkB: if (!(count_q <= 1) && cur_q != oldest_q && cur_q != newest_q)
        older_mem[rd_newer_q] <= rd_older_q;
      OpLinkA: if (count_q != 0) older_mem[cur_q] <= newest_q;
      OpLinkB: if (count_q != 0) newer_mem[newest_q] <= cur_q;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; oldest_q <= '0; newest_q <= '0; pend_idx_q <= '0;
      cur_q <= '0; scan_q <= '0; free_q <= '0; count_q <= '0; now_q <= '0;
      scan_idx_q <= '0; scan_v_q <= 1'b0;
      pend_q <= 1'b0; found_q <= 1'b0; free_ok_q <= 1'b0; scan_done_q <= 1'b0;
      valid_o <= 1'b0; status_o <= '0; out_handle_o <= '0; out_address_o <= '0;
      out_session_o <= '0; is_last_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.op == OpEmit;
      if (cmd_i.set_pend) begin pend_q <= 1'b1; pend_idx_q <= oldest_q; end
      if (cmd_i.clr_pend) pend_q <= 1'b0;
      unique case (cmd_i.op)
        OpLatch: begin
          if (cmd_i.sel_pend) now_q <= now_i;
          scan_q <= '0; found_q <= 1'b0; free_ok_q <= 1'b0; scan_done_q <= 1'b0;
          scan_v_q <= 1'b0;
        end
        OpScanStep: begin
          scan_v_q <= valid_q[scan_q] && !scan_done_q;
          scan_idx_q <= scan_q;
          if (hit && !found_q) begin found_q <= 1'b1; cur_q <= scan_idx_q; end
          if (!valid_q[scan_q] && !free_ok_q) begin free_ok_q <= 1'b1; free_q <= scan_q; end
          if (scan_q == LastIdx) scan_done_q <= 1'b1;
          else scan_q <= scan_q + 1'b1;
        end
        OpReadIdx: if (cmd_i.sel_pend) cur_q <= pend_idx_q;
        // new entry takes the lowest free index
        OpWriteNew: begin
          valid_q[free_q] <= 1'b1;
          cur_q <= free_q;
        end
        OpUnlinkA: begin
          if (count_q <= 1) count_q <= '0;
          else begin
            if (cur_q == oldest_q) oldest_q <= rd_newer_q;
            else if (cur_q == newest_q) newest_q <= rd_older_q;
            count_q <= count_q - 1'b1;
          end
        end
        OpLinkB: begin
          if (count_q == 0) oldest_q <= cur_q;
          newest_q <= cur_q;
          count_q <= count_q + 1'b1;
        end
        OpFree: valid_q[cur_q] <= 1'b0;
        OpEmit: begin
          status_o <= cmd_i.status;
          is_last_o <= cmd_i.last;
          out_handle_o <= cmd_i.with_entry ? rd_handle_q : '0;
          out_address_o <= cmd_i.with_entry ? rd_addr_q : '0;
          out_session_o <= cmd_i.with_entry ? rd_sess_q : '0;
        end
        default: ;
      endcase
    end
  end

  assign scan_done_o = scan_done_q;
  assign found_o = found_q;
  assign has_free_o = free_ok_q;
  assign empty_o = count_q == 0;
  assign idle_o = limit <= {1'b0, now_q};
  assign pending_o = pend_q;

  `ICAT_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, count_q <= Entries)
  `ICAT_ASSERT_IMP(a_cnt_pop, clk_i, rst_ni, valid_q == '0, count_q == 0)
  `ICAT_ASSERT_NXT(a_emit, clk_i, rst_ni, cmd_i.op == OpEmit, valid_o)
endmodule

@@ src/icat_ctrl.sv @@
// Controller: sequences lookup, list updates and result words per request.
// Depends on icat_pkg and the assertion macro header.
`include "idle_connection_aging_table_macros.svh"
module icat_ctrl import icat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [1:0] req_i,
  input  logic release_i,
  input  logic enable_i,
  input  logic scan_done_i,
  input  logic found_i,
  input  logic has_free_i,
  input  logic empty_i,
  input  logic idle_i,
  input  logic pending_i,
  output logic busy_o,
  output cmd_t cmd_o
);
  localparam logic [4:0] SIdle = 5'd0, SScan = 5'd1, SDecide = 5'd2, SRead = 5'd3,
    SReadW = 5'd4, SUnA = 5'd5, SUnB = 5'd6, SLinkA = 5'd7, SLinkB = 5'd8,
    SEmit1 = 5'd9, SOld = 5'd10, SOldW = 5'd11, SEmit2 = 5'd12, SDone = 5'd13,
    SFinal = 5'd14;

  logic [4:0] state_q, state_d;
  logic [1:0] req_q;
  logic rel_q, rel_d, new_q, new_d;
  logic [1:0] req_d;

  assign busy_o = state_q != SIdle;

  // Next state and command decode
  always_comb begin
    state_d = state_q; req_d = req_q; rel_d = rel_q; new_d = new_q;
    cmd_o = '{op: OpNone, sel_pend: 1'b0, status: StInserted, with_entry: 1'b0,
              last: 1'b1, set_pend: 1'b0, clr_pend: 1'b0};
    unique case (state_q)
      SIdle: if (start_i) begin
        req_d = req_i; rel_d = release_i; new_d = 1'b0;
        cmd_o.op = OpLatch;
        cmd_o.sel_pend = req_i == ReqTick && enable_i && !pending_i;
        state_d = SDecide;
        if (!enable_i) state_d = SFinal;
        else if (req_i == ReqVerdict) state_d = pending_i ? SRead : SFinal;
        else if (pending_i) state_d = SFinal;
        else if (req_i != ReqTick) state_d = SScan;
        else state_d = SOld;
      end
      SFinal: begin
        cmd_o.op = OpEmit;
        cmd_o.status = !enable_i ? StDisabled :
                       (req_q == ReqVerdict ? StNoPending : StBusy);
        state_d = SDone;
      end
      SScan: begin
        cmd_o.op = OpScanStep;
        if (scan_done_i) state_d = SDecide;
      end
      SDecide: begin
        if (found_i) state_d = SRead;
        else if (req_q == ReqClose) begin
          cmd_o.op = OpEmit; cmd_o.status = StNotFound; state_d = SDone;
        end else if (!has_free_i) begin
          cmd_o.op = OpEmit; cmd_o.status = StFull; state_d = SDone;
        end else begin
          cmd_o.op = OpWriteNew; new_d = 1'b1; state_d = SLinkA;
        end
      end
      SRead: begin
        cmd_o.op = OpReadIdx; cmd_o.sel_pend = req_q == ReqVerdict; state_d = SReadW;
      end
      SReadW: begin
        cmd_o.op = OpReadIdx; state_d = SUnA;
        if (req_q == ReqMsg) cmd_o.op = OpRefresh;
        else if (req_q == ReqVerdict && !rel_q) cmd_o.op = OpKeepTime;
      end
      SUnA: begin cmd_o.op = OpUnlinkB; state_d = SUnB; end
      SUnB: begin
        cmd_o.op = OpUnlinkA;
        state_d = (req_q == ReqClose || rel_q && req_q == ReqVerdict) ? SEmit1 : SLinkA;
      end
      SLinkA: begin cmd_o.op = OpLinkA; state_d = SLinkB; end
      SLinkB: begin cmd_o.op = OpLinkB; state_d = SEmit1; end
      SEmit1: begin
        cmd_o.op = OpEmit; cmd_o.with_entry = 1'b1;
        cmd_o.status = new_q ? StInserted :
          ((req_q == ReqClose || req_q == ReqVerdict && rel_q) ? StRemoved : StRefreshed);
        cmd_o.last = req_q != ReqVerdict;
        state_d = (req_q == ReqVerdict) ? SOld : SDone;
        if (req_q == ReqClose || req_q == ReqVerdict && rel_q) cmd_o.clr_pend = 1'b1;
      end
      SOld: begin
        if (req_q == ReqVerdict && rel_q) begin
          cmd_o.op = OpFree; state_d = SOld; rel_d = 1'b0; req_d = ReqTick;
        end else begin
          cmd_o.op = OpOldRead; state_d = SOldW;
        end
      end
      SOldW: state_d = SEmit2;
      SEmit2: begin
        cmd_o.op = OpEmit;
        if (!empty_i && idle_i) begin
          cmd_o.status = StIdleFound; cmd_o.with_entry = 1'b1; cmd_o.set_pend = 1'b1;
        end else begin
          cmd_o.status = StNoIdle; cmd_o.clr_pend = 1'b1;
        end
        state_d = SDone;
      end
      SDone: begin
        state_d = SIdle;
        if (req_q == ReqClose && found_i) cmd_o.op = OpFree;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; req_q <= ReqMsg; rel_q <= 1'b0; new_q <= 1'b0;
    end else begin
      state_q <= state_d; req_q <= req_d; rel_q <= rel_d; new_q <= new_d;
    end
  end

  `ICAT_ASSERT_IMP(a_start_idle, clk_i, rst_ni, state_q == SIdle && start_i, cmd_o.op == OpLatch)
  `ICAT_ASSERT_NXT(a_done_idle, clk_i, rst_ni, state_q == SDone, state_q == SIdle)
  `ICAT_ASSERT_IMP(a_busy, clk_i, rst_ni, cmd_o.op == OpEmit, busy_o)
endmodule

@@ src/idle_connection_aging_table.sv @@
// Top level of the idle connection aging table: config registers, controller, datapath.
// Depends on icat_pkg, icat_ctrl and icat_datapath.
//
// channel  | signals                                    | handshake
// request  | req_type_i conn_handle_i ... release_idle_i | start_i & !busy_o
// result   | status_o out_handle_o ... is_last_o        | done_o, one cycle
// config   | cfg_we_i cfg_idx_i cfg_data_i              | cfg_we_i
//
// Message and close items scan the keys of all TABLE_ENTRIES entries: the key
// scan reads one entry a cycle and compares it in the cycle after.
// Reset clears the valid bits at once; no clearing pass. No output stalls.
module idle_connection_aging_table import icat_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntries
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic [1:0] req_type_i,
  input  logic [HandleW-1:0] conn_handle_i,
  input  logic [AddrW-1:0] peer_address_i,
  input  logic signed [SessW-1:0] session_ident_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic release_idle_i,
  output logic done_o,
  output logic [StatusW-1:0] status_o,
  output logic [HandleW-1:0] out_handle_o,
  output logic [AddrW-1:0] out_address_o,
  output logic signed [SessW-1:0] out_session_o,
  output logic is_last_o,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic enable_q;
  logic [TimeoutW-1:0] timeout_q;
  cmd_t cmd;
  logic scan_done, found, has_free, empty, idle, pend;
  logic [SessW-1:0] sess_w;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      timeout_q <= TimeoutW'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEnable: enable_q <= cfg_data_i[0];
        CfgTimeout: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  icat_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .req_i(req_type_i), .release_i(release_idle_i),
    .enable_i(enable_q), .scan_done_i(scan_done), .found_i(found),
    .has_free_i(has_free), .empty_i(empty), .idle_i(idle), .pending_i(pend),
    .busy_o, .cmd_o(cmd)
  );

  icat_datapath #(.Entries(TABLE_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .handle_i(conn_handle_i), .addr_i(peer_address_i),
    .sess_i(session_ident_i), .now_i(now_ms_i), .timeout_i(timeout_q),
    .scan_done_o(scan_done), .found_o(found), .has_free_o(has_free),
    .empty_o(empty), .idle_o(idle), .pending_o(pend), .valid_o(done_o), .status_o,
    .out_handle_o, .out_address_o, .out_session_o(sess_w), .is_last_o
  );
  assign out_session_o = sess_w;
endmodule
